>>> rtl/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and constants of the voxel ray traversal block
// Grid geometry, fixed-point widths, register indexes and controller states.
// ----------------------------------------------------------------------------
package vrt_pkg;

  localparam int GRID_BITS  = 5;                      // 32 voxels per axis
  localparam int FRAC_BITS  = 16;
  localparam int ORG_W      = GRID_BITS + FRAC_BITS;  // 21
  localparam int DIR_W      = FRAC_BITS + 2;          // 18
  localparam int QUO_W      = 2 * FRAC_BITS + 1;      // 33, quotient and dividend width
  localparam int REM_W      = DIR_W;                  // remainder stays below the divisor
  localparam int WGT_W      = QUO_W + 7;              // weight plus up to 64 increments
  localparam int CELL_W     = 8;                      // signed voxel index while stepping
  localparam int OFFS_W     = 6;
  localparam int D2_W       = 2 * OFFS_W + 2;
  localparam int ADDR_W     = 3 * GRID_BITS;
  localparam int WORD_W     = 16;
  localparam int DIV_CNT_W  = 6;

  localparam logic [1:0] REG_MAX_RANGE  = 2'd0;
  localparam logic [1:0] REG_AIR_CODE   = 2'd1;
  localparam logic [1:0] REG_SOLID_MASK = 2'd2;
  localparam logic [1:0] REG_FLUID_MASK = 2'd3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_STEP  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

>>> rtl/voxel_ray_traversal.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal: voxel store with a 3D DDA ray caster
// A 32x32x32 store of 16-bit block words, loaded by write requests and
// searched by cast requests that step voxel by voxel until a selectable voxel or the range limit.
// ----------------------------------------------------------------------------
// Usage: one request is worked on at a time. A write request goes from
// acceptance to S_DONE, which hands its acknowledge over. A cast request
// with a zero direction does the same; any other is loaded, then runs the
// reciprocal dividers (six restoring dividers, one quotient bit a cycle,
// all axes in parallel), then the DDA steps: a step outside the grid stays
// in S_STEP, a step inside it goes on to S_CHECK for the voxel read (the
// voxel store is a single-port synchronous memory with a registered read),
// which ends a hit on a selectable voxel. A step that fails the range check
// ends a miss, and S_DONE hands the result over. With range R a cast makes
// at most about 1.75*R steps. The result sits in an output register, so
// the next request is taken while it waits on m_tready.
// Configuration writes take effect at once and must only come while idle.
// ----------------------------------------------------------------------------
module voxel_ray_traversal
  import vrt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // request channel
  input  logic         s_tvalid,
  output logic         s_tready,
  // voxel_x[4:0], voxel_y[9:5], voxel_z[14:10], block_word[30:15],
  // origin_x[51:31], origin_y[72:52], origin_z[93:73],
  // dir_x[111:94], dir_y[129:112], dir_z[147:130], zero fill above
  input  logic [151:0] s_tdata,
  // action[0]
  input  logic [0:0]   s_tuser,
  // result channel
  output logic         m_tvalid,
  input  logic         m_tready,
  // hit_x[6:0], hit_y[13:7], hit_z[20:14], hit_axis[22:21], zero fill above
  output logic [23:0]  m_tdata,
  // hit[0], write_done[1]
  output logic [1:0]   m_tuser,
  // configuration write port
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  // configuration registers
  logic [4:0]        max_range;
  logic [WORD_W-1:0] air_code;
  logic [WORD_W-1:0] solid_mask;
  logic [WORD_W-1:0] fluid_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_range  <= 5'd8;
      air_code   <= '0;
      solid_mask <= 16'h8000;
      fluid_mask <= 16'h4000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_RANGE:  max_range  <= cfg_data[4:0];
        REG_AIR_CODE:   air_code   <= cfg_data;
        REG_SOLID_MASK: solid_mask <= cfg_data;
        REG_FLUID_MASK: fluid_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // request fields
  logic                 in_action;
  logic [ADDR_W-1:0]    in_addr;
  logic [WORD_W-1:0]    in_word;
  logic [ORG_W-1:0]     in_org [3];
  logic [DIR_W-1:0]     in_dir [3];

  assign in_action = s_tuser[0];
  assign in_addr   = {s_tdata[14:10], s_tdata[9:5], s_tdata[4:0]};
  assign in_word   = s_tdata[30:15];
  assign in_org[0] = s_tdata[51:31];
  assign in_org[1] = s_tdata[72:52];
  assign in_org[2] = s_tdata[93:73];
  assign in_dir[0] = s_tdata[111:94];
  assign in_dir[1] = s_tdata[129:112];
  assign in_dir[2] = s_tdata[147:130];

  state_t state, state_next;
  logic   accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // per-axis load values
  logic [DIR_W-1:0]     ld_mag  [3];
  logic [FRAC_BITS:0]   ld_dist [3];
  logic                 any_dir;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ld_mag[a]  = in_dir[a][DIR_W-1] ? (DIR_W'(0) - in_dir[a]) : in_dir[a];
      ld_dist[a] = in_dir[a][DIR_W-1] ? {1'b0, in_org[a][FRAC_BITS-1:0]}
                 : ((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, in_org[a][FRAC_BITS-1:0]};
    end
    any_dir = (ld_mag[0] != '0) || (ld_mag[1] != '0) || (ld_mag[2] != '0);
  end

  // ray state
  logic [DIR_W-1:0]         mag   [3];
  logic                     neg   [3];
  logic                     inf   [3];
  logic signed [CELL_W-1:0] pos   [3];
  logic [OFFS_W-1:0]        offs  [3];
  logic [WGT_W-1:0]         wgt   [3];
  logic [QUO_W-1:0]         dq    [3];   // increment quotient, shifted in bit by bit
  logic [QUO_W-1:0]         wq    [3];   // first weight quotient
  logic [REM_W-1:0]         drem  [3];
  logic [REM_W-1:0]         wrem  [3];
  logic [DIV_CNT_W-1:0]     div_cnt;
  logic [1:0]               last_axis;

  // divider step
  logic [REM_W:0]   dtmp [3];
  logic [REM_W:0]   wtmp [3];
  logic             dge  [3];
  logic             wge  [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dtmp[a] = {drem[a], dq[a][QUO_W-1]};
      wtmp[a] = {wrem[a], wq[a][QUO_W-1]};
      dge[a]  = dtmp[a] >= {1'b0, mag[a]};
      wge[a]  = wtmp[a] >= {1'b0, mag[a]};
    end
  end

  // DDA step: pick the axis with least weight, infinite weights never win
  logic                     lt_xy, lt_xz, lt_yz;
  logic [1:0]               axis;
  logic [OFFS_W-1:0]        offs_n [3];
  logic [D2_W-1:0]          d2;
  logic [9:0]               lim;
  logic signed [CELL_W-1:0] pos_n [3];
  logic                     in_win;
  logic [ADDR_W-1:0]        rd_addr;

  always_comb begin
    lt_xy = !inf[0] && (inf[1] || (wgt[0] < wgt[1]));
    lt_xz = !inf[0] && (inf[2] || (wgt[0] < wgt[2]));
    lt_yz = !inf[1] && (inf[2] || (wgt[1] < wgt[2]));
    if (lt_xy && lt_xz) begin
      axis = 2'd0;
    end else if (lt_yz) begin
      axis = 2'd1;
    end else begin
      axis = 2'd2;
    end
    for (int a = 0; a < 3; a++) begin
      offs_n[a] = (axis == 2'(a)) ? offs[a] + OFFS_W'(1) : offs[a];
      pos_n[a]  = (axis == 2'(a)) ? (neg[a] ? pos[a] - CELL_W'(1) : pos[a] + CELL_W'(1))
                                  : pos[a];
    end
    d2 = D2_W'(offs_n[0]) * D2_W'(offs_n[0]) + D2_W'(offs_n[1]) * D2_W'(offs_n[1])
       + D2_W'(offs_n[2]) * D2_W'(offs_n[2]);
    lim = 10'(max_range) * 10'(max_range);
    in_win = (pos_n[0][CELL_W-1:GRID_BITS] == '0) && (pos_n[1][CELL_W-1:GRID_BITS] == '0)
          && (pos_n[2][CELL_W-1:GRID_BITS] == '0);
    rd_addr = {pos_n[2][GRID_BITS-1:0], pos_n[1][GRID_BITS-1:0],
               pos_n[0][GRID_BITS-1:0]};
  end

  // voxel store: writes only while idle, reads only while stepping, so
  // the two never touch the same cycle and need no forwarding
  logic [WORD_W-1:0] voxel_mem [2**ADDR_W];
  logic [WORD_W-1:0] rd_data;
  logic              mem_we;
  logic              rd_en;
  logic              step_ok;

  assign mem_we  = accept && (in_action == ACT_WRITE);
  assign step_ok = (state == S_STEP) && (d2 <= 14'(lim));
  assign rd_en   = step_ok && in_win;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      voxel_mem[in_addr] <= in_word;
    end
    if (rd_en) begin
      rd_data <= voxel_mem[rd_addr];
    end
  end

  logic selectable;
  assign selectable = (rd_data != air_code)
                   && !(((rd_data & solid_mask) == '0) && ((rd_data & fluid_mask) != '0));

  // pending result, handed to the output register in S_DONE
  logic       res_hit;
  logic       res_wdone;
  logic [1:0] res_axis;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (in_action == ACT_CAST && any_dir) ? S_DIV : S_DONE;
        end
      end
      S_DIV: begin
        if (div_cnt == DIV_CNT_W'(QUO_W - 1)) state_next = S_STEP;
      end
      S_STEP: begin
        if (!step_ok) begin
          state_next = S_DONE;
        end else if (in_win) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = selectable ? S_DONE : S_STEP;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        res_hit   <= 1'b0;
        res_wdone <= (in_action == ACT_WRITE);
        res_axis  <= 2'd0;
        div_cnt   <= '0;
        for (int a = 0; a < 3; a++) begin
          mag[a]  <= ld_mag[a];
          neg[a]  <= in_dir[a][DIR_W-1];
          inf[a]  <= (ld_mag[a] == '0);
          pos[a]  <= CELL_W'(in_org[a][ORG_W-1:FRAC_BITS]);
          offs[a] <= '0;
          dq[a]   <= QUO_W'(1) << (QUO_W - 1);
          wq[a]   <= {ld_dist[a], FRAC_BITS'(0)};
          drem[a] <= '0;
          wrem[a] <= '0;
        end
      end
      S_DIV: begin
        // advance all six dividers by one quotient bit
        div_cnt <= div_cnt + DIV_CNT_W'(1);
        for (int a = 0; a < 3; a++) begin
          drem[a] <= dge[a] ? REM_W'(dtmp[a] - {1'b0, mag[a]}) : dtmp[a][REM_W-1:0];
          wrem[a] <= wge[a] ? REM_W'(wtmp[a] - {1'b0, mag[a]}) : wtmp[a][REM_W-1:0];
          dq[a]   <= {dq[a][QUO_W-2:0], dge[a]};
          wq[a]   <= {wq[a][QUO_W-2:0], wge[a]};
          if (div_cnt == DIV_CNT_W'(QUO_W - 1)) begin
            wgt[a] <= WGT_W'({wq[a][QUO_W-2:0], wge[a]});
          end
        end
      end
      S_STEP: begin
        if (step_ok) begin
          last_axis <= axis;
          for (int a = 0; a < 3; a++) begin
            offs[a] <= offs_n[a];
            pos[a]  <= pos_n[a];
            if (axis == 2'(a)) wgt[a] <= wgt[a] + WGT_W'(dq[a]);
          end
        end
      end
      S_CHECK: begin
        if (selectable) begin
          res_hit  <= 1'b1;
          res_axis <= last_axis;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tuser <= {res_wdone, res_hit};
      if (res_hit) begin
        m_tdata <= {1'b0, res_axis, pos[2][6:0], pos[1][6:0], pos[0][6:0]};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  // checks
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("hit and write acknowledge raised together");

  a_check_after_step: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> $past(state) == S_STEP)
    else $error("voxel check without a preceding read");

  a_write_to_done: assert property (@(posedge clk) disable iff (rst)
    (accept && in_action == ACT_WRITE) |=> state == S_DONE)
    else $error("write request did not go straight to its acknowledge");

  a_cast_to_div: assert property (@(posedge clk) disable iff (rst)
    (accept && in_action == ACT_CAST && any_dir) |=> state == S_DIV)
    else $error("cast request skipped the reciprocal dividers");

endmodule
